>>> design/ordered_list_insert_remove_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ordered list unit
// Shared property forms used by the checker of the ordered list unit.
// ---------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is applied.
`define OLIST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked also during reset.
`define OLIST_ASSERT_NXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/olist_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ordered list package
// Sizes, operation and status codes, and the structs shared by the modules.
// ---------------------------------------------------------------------------
package olist_pkg;

  localparam int CAPACITY  = 256;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KIND_W    = 3;
  localparam int POS_W     = 9;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 9;
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [KIND_W-1:0] KIND_APPEND       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PREPEND      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE_FIRST = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE_LAST  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR        = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READ         = 3'd6;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic                     valid;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_value;
    logic [OUT_CNT_W-1:0]     count;
    logic                     is_full;
    logic                     is_empty;
  } result_t;

endpackage

>>> design/ordered_list_insert_remove_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ordered list insert and remove unit
// Keeps an ordered list of signed 32-bit values in a single-port-pair RAM
// with an element count, and answers one result per command.
// ---------------------------------------------------------------------------
//  Channel   Handshake            Ports
//  command   start & !busy        in_kind, in_position, in_value
//  result    out_valid, 1 cycle   out_status, out_read_value, out_count,
//                                 out_is_full, out_is_empty
//
// Append, insert at the end, remove last, clear, the unused code and rejected
// commands give their result in the cycle after the transfer; a read passes
// through S_READ. Other prepends and inserts run S_UP and then S_PUT, and
// remove first on two or more entries runs S_DOWN: the shift moves one entry
// per cycle through the RAM's single write port, reading one entry ahead.
// After reset the list is empty; the store itself is not cleared.
// The result strobe lasts one cycle and cannot be stalled; busy is high
// only while a shift or read is in flight.
// ---------------------------------------------------------------------------
module ordered_list_insert_remove_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [olist_pkg::KIND_W-1:0]        in_kind,
  input  logic [olist_pkg::POS_W-1:0]         in_position,
  input  logic signed [olist_pkg::DATA_W-1:0] in_value,
  output logic                                out_valid,
  output logic [olist_pkg::STATUS_W-1:0]      out_status,
  output logic signed [olist_pkg::DATA_W-1:0] out_read_value,
  output logic [olist_pkg::OUT_CNT_W-1:0]     out_count,
  output logic                                out_is_full,
  output logic                                out_is_empty
);

  import olist_pkg::*;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  result_t           result;

  olist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .kind      (in_kind),
    .position  (in_position),
    .value     (in_value),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .result    (result)
  );

  olist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign out_valid      = result.valid;
  assign out_status     = result.status;
  assign out_read_value = result.read_value;
  assign out_count      = result.count;
  assign out_is_full    = result.is_full;
  assign out_is_empty   = result.is_empty;

endmodule

>>> design/olist_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module olist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/olist_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ordered list sequencer
// Decodes each operation, runs the element shifts through the store and
// registers the result.
// ---------------------------------------------------------------------------
module olist_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [olist_pkg::KIND_W-1:0]      kind,
  input  logic [olist_pkg::POS_W-1:0]       position,
  input  logic signed [olist_pkg::DATA_W-1:0] value,
  output olist_pkg::ram_req_t               ram_req,
  input  logic [olist_pkg::DATA_W-1:0]      ram_rdata,
  output olist_pkg::result_t                result
);

  import olist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UP,
    S_PUT,
    S_DOWN
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  logic [ADDR_W-1:0]   pos_r;
  logic [DATA_W-1:0]   val_r;
  logic [ADDR_W-1:0]   wr_idx_r;
  result_t             result_r;

  logic                is_full;
  logic                is_empty;
  logic [POS_W-1:0]    eff_pos;
  logic                pos_gt;
  logic                pos_ge;
  logic                pos_at_end;
  logic [CNT_W-1:0]    count_inc;
  logic [CNT_W-1:0]    count_dec;

  function automatic result_t make_result(input logic [STATUS_W-1:0] status,
                                          input logic [DATA_W-1:0] rd,
                                          input logic [CNT_W-1:0] cnt);
    result_t r;
    r.valid      = 1'b1;
    r.status     = status;
    r.read_value = rd;
    r.count      = OUT_CNT_W'(cnt);
    r.is_full    = (cnt == CNT_W'(CAPACITY));
    r.is_empty   = (cnt == '0);
    return r;
  endfunction

  assign is_full    = (count_r == CNT_W'(CAPACITY));
  assign is_empty   = (count_r == '0);
  assign eff_pos    = (kind == KIND_PREPEND) ? '0 : position;
  assign pos_gt     = (CMP_W'(eff_pos) > CMP_W'(count_r));
  assign pos_ge     = (CMP_W'(eff_pos) >= CMP_W'(count_r));
  assign pos_at_end = (CMP_W'(eff_pos) == CMP_W'(count_r));
  assign count_inc  = count_r + CNT_W'(1);
  assign count_dec  = count_r - CNT_W'(1);

  always_comb begin
    ram_req       = '0;
    ram_req.wdata = val_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (kind)
            KIND_APPEND: begin
              if (!is_full) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ADDR_W'(count_r);
                ram_req.wdata = value;
              end
            end
            KIND_PREPEND, KIND_INSERT: begin
              if (!is_full && !pos_gt) begin
                if (pos_at_end) begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = ADDR_W'(count_r);
                  ram_req.wdata = value;
                end else begin
                  ram_req.raddr = ADDR_W'(count_dec);
                end
              end
            end
            KIND_REMOVE_FIRST: begin
              ram_req.raddr = ADDR_W'(1);
            end
            KIND_READ: begin
              ram_req.raddr = ADDR_W'(position);
            end
            default: begin
            end
          endcase
        end
      end
      S_UP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = wr_idx_r;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = wr_idx_r - ADDR_W'(2);
      end
      S_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        ram_req.wdata = val_r;
      end
      S_DOWN: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = wr_idx_r;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = wr_idx_r + ADDR_W'(2);
      end
      S_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result_t result_nxt;
    result_nxt       = result_r;
    result_nxt.valid = 1'b0;
    if (!rst_n) begin
      state_r        <= S_IDLE;
      count_r        <= '0;
      result_r.valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            pos_r    <= ADDR_W'(eff_pos);
            val_r    <= value;
            wr_idx_r <= (kind == KIND_REMOVE_FIRST) ? '0 : ADDR_W'(count_r);
            unique case (kind)
              KIND_APPEND: begin
                if (is_full) begin
                  result_nxt = make_result(STATUS_FULL, '0, count_r);
                end else begin
                  count_r    <= count_inc;
                  result_nxt = make_result(STATUS_OK, '0, count_inc);
                end
              end
              KIND_PREPEND, KIND_INSERT: begin
                if (is_full) begin
                  result_nxt = make_result(STATUS_FULL, '0, count_r);
                end else if (pos_gt) begin
                  result_nxt = make_result(STATUS_RANGE, '0, count_r);
                end else if (pos_at_end) begin
                  count_r    <= count_inc;
                  result_nxt = make_result(STATUS_OK, '0, count_inc);
                end else begin
                  state_r <= S_UP;
                end
              end
              KIND_REMOVE_FIRST: begin
                if (is_empty) begin
                  result_nxt = make_result(STATUS_EMPTY, '0, count_r);
                end else if (count_r == CNT_W'(1)) begin
                  count_r    <= '0;
                  result_nxt = make_result(STATUS_OK, '0, '0);
                end else begin
                  state_r <= S_DOWN;
                end
              end
              KIND_REMOVE_LAST: begin
                if (is_empty) begin
                  result_nxt = make_result(STATUS_EMPTY, '0, count_r);
                end else begin
                  count_r    <= count_dec;
                  result_nxt = make_result(STATUS_OK, '0, count_dec);
                end
              end
              KIND_CLEAR: begin
                count_r    <= '0;
                result_nxt = make_result(STATUS_OK, '0, '0);
              end
              KIND_READ: begin
                if (is_empty) begin
                  result_nxt = make_result(STATUS_EMPTY, '0, count_r);
                end else if (pos_ge) begin
                  result_nxt = make_result(STATUS_RANGE, '0, count_r);
                end else begin
                  state_r <= S_READ;
                end
              end
              default: begin
                result_nxt = make_result(STATUS_OK, '0, count_r);
              end
            endcase
          end
        end
        S_READ: begin
          result_nxt = make_result(STATUS_OK, ram_rdata, count_r);
          state_r    <= S_IDLE;
        end
        S_UP: begin
          if (CNT_W'(wr_idx_r) > (CNT_W'(pos_r) + CNT_W'(1))) begin
            wr_idx_r <= wr_idx_r - ADDR_W'(1);
          end else begin
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          count_r    <= count_inc;
          result_nxt = make_result(STATUS_OK, '0, count_inc);
          state_r    <= S_IDLE;
        end
        S_DOWN: begin
          if ((CNT_W'(wr_idx_r) + CNT_W'(2)) < count_r) begin
            wr_idx_r <= wr_idx_r + ADDR_W'(1);
          end else begin
            count_r    <= count_dec;
            result_nxt = make_result(STATUS_OK, '0, count_dec);
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      result_r <= result_nxt;
    end
  end

  assign busy   = (state_r != S_IDLE);
  assign result = result_r;

endmodule

>>> design/olist_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ordered list port checker
// Watches the ports of the ordered list unit for consistent results.
// ---------------------------------------------------------------------------
`include "ordered_list_insert_remove_unit_defines.svh"

module olist_port_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic [olist_pkg::STATUS_W-1:0]      out_status,
  input logic signed [olist_pkg::DATA_W-1:0] out_read_value,
  input logic [olist_pkg::OUT_CNT_W-1:0]     out_count,
  input logic                                out_is_full,
  input logic                                out_is_empty
);

  import olist_pkg::*;

  `OLIST_ASSERT_NXT(a_reset_quiet, clk, !rst_n, !out_valid && !busy, "reset did not clear the unit")
  `OLIST_ASSERT_IMP(a_empty_flag, clk, rst_n, out_valid, out_is_empty == (out_count == '0), "empty flag disagrees with count")
  `OLIST_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid, !(out_is_full && out_is_empty), "full and empty both set")
  `OLIST_ASSERT_IMP(a_err_no_data, clk, rst_n, out_valid && (out_status != STATUS_OK), out_read_value == '0, "failed command returned data")
  `OLIST_ASSERT_IMP(a_full_status, clk, rst_n, out_valid && (out_status == STATUS_FULL), out_is_full, "full status on a list that is not full")

endmodule

bind ordered_list_insert_remove_unit olist_port_checker u_olist_port_checker (.*);
